// ----- hdl/u2h_pkg.sv -----
// shared types and constants for the utf-8 to ucs-2 hex converter
// no dependencies; compiled first

package u2h_pkg;

    localparam int QueueDepth   = 2;
    localparam int QPtrW        = $clog2(QueueDepth);
    localparam int QCountW      = $clog2(QueueDepth + 1);

    localparam int ByteW        = 8;
    localparam int UnitW        = 16;
    localparam int CharW        = 7;
    localparam int NibbleW      = 4;
    localparam int DigitW       = 2;
    localparam int PendW        = 3;
    localparam int LeadW        = 4;

    localparam logic [DigitW-1:0] DigitLast    = 2'd3;
    localparam logic [CharW-1:0]  AsciiZero    = 7'h30;
    localparam logic [CharW-1:0]  HexAlphaBase = 7'h37;  // 'A' minus ten
    localparam logic [NibbleW-1:0] NibbleNine  = 4'd9;
    localparam logic [5:0]        ContMask     = 6'h3F;

    // one decoded code unit, as passed from decoder to serializer
    typedef struct packed {
        logic [UnitW-1:0] code;
        logic             unsup;
    } t_unit;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/u2h_if.sv -----
// handshake channels for byte input and hex character output
// depends on u2h_pkg

interface u2h_in_if;
    logic                        valid;
    logic                        ready;
    logic [u2h_pkg::ByteW-1:0]   byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u2h_out_if;
    logic                        valid;
    logic                        ready;
    logic [u2h_pkg::UnitW-1:0]   code_unit;
    logic [u2h_pkg::CharW-1:0]   hex_char;
    logic                        last_digit;
    logic                        unsupported;

    modport source (output valid, output code_unit, output hex_char,
                    output last_digit, output unsupported, input ready);
    modport sink   (input valid, input code_unit, input hex_char,
                    input last_digit, input unsupported, output ready);
endinterface

// ----- hdl/u2h_front.sv -----
// front end: accepts bytes, tracks the utf-8 sequence, pushes finished code units
// depends on u2h_pkg and u2h_if

module u2h_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    u2h_in_if.sink              i_byte,
    input  logic                i_q_full,
    output logic                o_push,
    output u2h_pkg::t_unit      o_push_data
);
    import u2h_pkg::*;

    logic [PendW-1:0]  r_pending, n_pending;
    logic [UnitW-1:0]  r_partial, n_partial;
    logic              r_unsup,   n_unsup;

    logic              accept;
    logic [ByteW-1:0]  b;
    logic [LeadW-1:0]  lead_ones;
    logic [UnitW-1:0]  shifted;
    logic [PendW-1:0]  pend_dec;

    function automatic logic [LeadW-1:0] count_lead(input logic [ByteW-1:0] v);
        logic [LeadW-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int k = ByteW - 1; k >= 0; k--) begin
            run = run & v[k];
            n   = n + {{(LeadW-1){1'b0}}, run};
        end
        return n;
    endfunction

    assign i_byte.ready = !i_q_full;
    assign accept       = i_byte.valid && !i_q_full;
    assign b            = i_byte.byte_in;
    assign lead_ones    = count_lead(b);
    assign shifted      = {r_partial[UnitW-7:0], b[5:0] & ContMask};
    assign pend_dec     = r_pending - PendW'(1);

    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_unsup     = r_unsup;
        o_push      = 1'b0;
        o_push_data = '{code: '0, unsup: 1'b0};
        if (accept) begin
            priority if (b == '0) begin
                // end of string drops any partial sequence
                n_pending = '0;
                n_partial = '0;
                n_unsup   = 1'b0;
            end else if (r_pending != '0) begin
                // taken as a continuation without checking its top bits
                n_pending = pend_dec;
                if (!r_unsup) begin
                    n_partial = shifted;
                end
                if (pend_dec == '0) begin
                    o_push      = 1'b1;
                    o_push_data = '{code: r_unsup ? '0 : shifted, unsup: r_unsup};
                    n_partial   = '0;
                    n_unsup     = 1'b0;
                end
            end else begin
                unique case (lead_ones)
                    LeadW'(0): begin
                        o_push      = 1'b1;
                        o_push_data = '{code: {{(UnitW-ByteW){1'b0}}, b}, unsup: 1'b0};
                    end
                    LeadW'(1): begin
                        // stray continuation byte
                        o_push      = 1'b1;
                        o_push_data = '{code: '0, unsup: 1'b1};
                    end
                    LeadW'(2): begin
                        n_partial = {{(UnitW-5){1'b0}}, b[4:0]};
                        n_unsup   = 1'b0;
                        n_pending = PendW'(1);
                    end
                    LeadW'(3): begin
                        n_partial = {{(UnitW-4){1'b0}}, b[3:0]};
                        n_unsup   = 1'b0;
                        n_pending = PendW'(2);
                    end
                    default: begin
                        // four or more leading ones: swallow the tail, emit flagged zero
                        n_partial = '0;
                        n_unsup   = 1'b1;
                        n_pending = PendW'(lead_ones - LeadW'(1));
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_partial <= '0;
            r_unsup   <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_unsup   <= n_unsup;
        end
    end

endmodule

// ----- hdl/u2h_queue.sv -----
// short queue of decoded code units between decoder and serializer
// depends on u2h_pkg

module u2h_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u2h_pkg::t_unit      i_push_data,
    input  logic                i_pop,
    output u2h_pkg::t_unit      o_head,
    output u2h_pkg::t_q_status  o_status
);
    import u2h_pkg::*;

    t_unit               r_mem [QueueDepth];
    logic [QPtrW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [QCountW-1:0]  r_count,  n_count;
    logic                do_push;
    logic                do_pop;

    function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
        return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
    endfunction

    assign o_status.full  = (r_count == QCountW'(QueueDepth));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = do_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + QCountW'(do_push) - QCountW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hdl/u2h_back.sv -----
// back end: turns each code unit into four hex characters, one per cycle while o_char.ready is high
// depends on u2h_pkg and u2h_if

module u2h_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u2h_pkg::t_unit      i_head,
    input  u2h_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    u2h_out_if.source           o_char
);
    import u2h_pkg::*;

    logic              r_valid, n_valid;
    t_unit             r_unit,  n_unit;
    logic [DigitW-1:0] r_digit, n_digit;
    logic              out_take;
    logic              slot_free;
    logic [NibbleW-1:0] nib;

    assign out_take  = r_valid && o_char.ready;
    assign slot_free = !r_valid || (out_take && r_digit == DigitLast);
    assign o_pop     = slot_free && !i_q_status.empty;

    // high nibble first
    always_comb begin
        unique case (r_digit)
            2'd0:    nib = r_unit.code[15:12];
            2'd1:    nib = r_unit.code[11:8];
            2'd2:    nib = r_unit.code[7:4];
            default: nib = r_unit.code[3:0];
        endcase
    end

    assign o_char.valid       = r_valid;
    assign o_char.code_unit   = r_unit.code;
    assign o_char.hex_char    = {{(CharW-NibbleW){1'b0}}, nib}
                                + ((nib > NibbleNine) ? HexAlphaBase : AsciiZero);
    assign o_char.last_digit  = (r_digit == DigitLast);
    assign o_char.unsupported = r_unit.unsup;

    always_comb begin
        n_valid = r_valid;
        n_unit  = r_unit;
        n_digit = r_digit;
        if (slot_free) begin
            n_valid = !i_q_status.empty;
            n_unit  = i_head;
            n_digit = '0;
        end else if (out_take) begin
            n_digit = r_digit + DigitW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit <= n_unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_digit <= '0;
        end else begin
            r_valid <= n_valid;
            r_digit <= n_digit;
        end
    end

endmodule

// ----- hdl/utf8_to_ucs2_hex.sv -----
// top level of the utf-8 to ucs-2 hex converter
// depends on u2h_pkg, u2h_if, u2h_front, u2h_queue, u2h_back
//
// usage:
//   i_byte takes one utf-8 byte per item (valid/ready); a zero byte ends the
//   string and drops any half-finished sequence without producing output.
//   o_char gives one upper-case ascii hex digit per item, high nibble first,
//   together with the whole code unit, a last-digit mark and the unsupported
//   flag. every finished code unit (ascii, two- or three-byte sequence, or a
//   flagged zero for longer sequences and stray continuation bytes) yields
//   exactly four items.
//   a byte that completes a unit is written into the queue and then loaded
//   into the serializer register, which drives its first digit.
//   throughput: one digit per cycle while o_char.ready is high, the next unit
//   loading as the last is taken; bytes one per cycle while the two-entry queue has room.
//   stalls: when o_char.ready is low the digit holds, the queue fills and
//   i_byte.ready drops; both sides resume without loss.
//   reset: synchronous active low; clears the decoder state, the queue and
//   the output valid.

module utf8_to_ucs2_hex (
    input  logic    i_clk,
    input  logic    i_rst_n,
    u2h_in_if.sink  i_byte,
    u2h_out_if.source o_char
);
    import u2h_pkg::*;

    logic       push;
    t_unit      push_data;
    logic       pop;
    t_unit      head;
    t_q_status  q_status;

    u2h_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_q_full    (q_status.full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    u2h_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    u2h_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_char     (o_char)
    );

`ifndef SYNTHESIS
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("code unit pushed into a full queue");

    a_unit_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char.valid && o_char.ready && !o_char.last_digit)
        |=> (o_char.valid && o_char.code_unit == $past(o_char.code_unit)))
        else $error("code unit changed before its last digit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_char.valid)
        else $error("output valid right after reset");
`endif

endmodule

// ----- tb/u2h_digit_checker.sv -----
// watches both channels of the utf-8 to ucs-2 hex converter, decodes the byte stream itself
// and compares every hex digit item against the expected one; depends on u2h_pkg
`timescale 1ns / 100ps

module u2h_digit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_byte_valid,
    input  logic                        i_byte_ready,
    input  logic [u2h_pkg::ByteW-1:0]   i_byte_data,
    input  logic                        i_char_valid,
    input  logic                        i_char_ready,
    input  logic [u2h_pkg::UnitW-1:0]   i_char_code,
    input  logic [u2h_pkg::CharW-1:0]   i_char_hex,
    input  logic                        i_char_last,
    input  logic                        i_char_unsup,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_units,
    output int                          o_flagged_units
);
    import u2h_pkg::*;

    localparam logic [CharW-1:0] CharZero   = 7'h30;
    localparam logic [CharW-1:0] CharUpperA = 7'h41;
    localparam int               ReportMax  = 10;

    typedef struct packed {
        logic [UnitW-1:0] code;
        logic [CharW-1:0] hex;
        logic             last;
        logic             unsup;
    } t_hex_digit;

    t_hex_digit digit_q[$];

    // decoder state
    logic [PendW-1:0] cont_left;
    logic [UnitW-1:0] gathered;
    logic             flagged;

    function automatic logic [CharW-1:0] nibble_char(logic [NibbleW-1:0] nib);
        if (nib > 4'd9) begin
            return CharUpperA + CharW'(nib) - 7'd10;
        end
        return CharZero + CharW'(nib);
    endfunction

    function automatic int count_lead_ones(logic [ByteW-1:0] b);
        int n;
        n = 0;
        while (n < ByteW && b[ByteW-1-n]) begin
            n++;
        end
        return n;
    endfunction

    task automatic queue_unit_digits(logic [UnitW-1:0] unit, logic unsup);
        t_hex_digit d;
        for (int k = 0; k < 4; k++) begin
            d.code  = unit;
            d.hex   = nibble_char(unit[UnitW-1-4*k -: NibbleW]);
            d.last  = (k == 3);
            d.unsup = unsup;
            digit_q.push_back(d);
        end
    endtask

    task automatic decode_byte(logic [ByteW-1:0] b);
        int ones;
        if (b == '0) begin
            // end of string drops whatever was half done
            cont_left = '0;
            gathered  = '0;
            flagged   = 1'b0;
        end else if (cont_left != '0) begin
            // top bits of a continuation are never checked
            if (!flagged) begin
                gathered = {gathered[UnitW-7:0], b[5:0]};
            end
            cont_left = cont_left - 1'b1;
            if (cont_left == '0) begin
                queue_unit_digits(flagged ? '0 : gathered, flagged);
                gathered = '0;
                flagged  = 1'b0;
            end
        end else begin
            ones = count_lead_ones(b);
            case (ones)
                0: begin
                    queue_unit_digits({8'h00, b}, 1'b0);
                end
                1: begin
                    queue_unit_digits('0, 1'b1);
                end
                2: begin
                    gathered  = {11'd0, b[4:0]};
                    flagged   = 1'b0;
                    cont_left = 3'd1;
                end
                3: begin
                    gathered  = {12'd0, b[3:0]};
                    flagged   = 1'b0;
                    cont_left = 3'd2;
                end
                default: begin
                    gathered  = '0;
                    flagged   = 1'b1;
                    cont_left = PendW'(ones - 1);
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_hex_digit got;
        t_hex_digit want;
        if (!i_rst_n) begin
            cont_left       = '0;
            gathered        = '0;
            flagged         = 1'b0;
            o_mismatches    = 0;
            o_units         = 0;
            o_flagged_units = 0;
            digit_q.delete();
        end else begin
            if (i_byte_valid && i_byte_ready) begin
                decode_byte(i_byte_data);
            end
            if (i_char_valid && i_char_ready) begin
                got = '{code: i_char_code, hex: i_char_hex, last: i_char_last,
                        unsup: i_char_unsup};
                if (digit_q.size() == 0) begin
                    if (o_mismatches < ReportMax) begin
                        $display("%0t: unexpected digit item code=%h hex=%h last=%b unsup=%b",
                                 $realtime, got.code, got.hex, got.last, got.unsup);
                    end
                    o_mismatches++;
                end else begin
                    want = digit_q.pop_front();
                    if (got.code != want.code || got.hex != want.hex
                            || got.last != want.last || got.unsup != want.unsup) begin
                        if (o_mismatches < ReportMax) begin
                            $display("%0t: digit mismatch exp code=%h hex=%h last=%b unsup=%b",
                                     $realtime, want.code, want.hex, want.last, want.unsup);
                            $display("%0t:                got code=%h hex=%h last=%b unsup=%b",
                                     $realtime, got.code, got.hex, got.last, got.unsup);
                        end
                        o_mismatches++;
                    end else if (want.last) begin
                        o_units++;
                        if (want.unsup) begin
                            o_flagged_units++;
                        end
                    end
                end
            end
        end
        o_pending = digit_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// top of the converter testbench: clock, reset, byte stimulus, output back-pressure, verdict
// depends on u2h_pkg, u2h_if, utf8_to_ucs2_hex and u2h_digit_checker
`timescale 1ns / 100ps

module tb_top;
    import u2h_pkg::*;

    localparam int ItemTarget    = 300;
    localparam int HoldCycles    = 80;
    localparam int WatchdogLimit = 2000;
    localparam int SettleCycles  = 8;

    localparam logic [ByteW-1:0] DirectedBytes [26] = '{
        8'h00, 8'h01, 8'h7F,
        8'hC2, 8'h80,
        8'hEF, 8'hBF, 8'hBF,
        8'h80,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hFF, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
        8'hC3, 8'h41,
        8'hE2, 8'h82, 8'h00
    };

    logic i_clk;
    logic i_rst_n;

    u2h_in_if  byte_ch ();
    u2h_out_if char_ch ();

    int mismatches;
    int pending;
    int units;
    int flagged_units;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_req;
    int hold_ack;
    int sent_bytes;
    int idle_cycles;
    bit held;
    bit paused;

    utf8_to_ucs2_hex dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch)
    );

    u2h_digit_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_valid    (byte_ch.valid),
        .i_byte_ready    (byte_ch.ready),
        .i_byte_data     (byte_ch.byte_in),
        .i_char_valid    (char_ch.valid),
        .i_char_ready    (char_ch.ready),
        .i_char_code     (char_ch.code_unit),
        .i_char_hex      (char_ch.hex_char),
        .i_char_last     (char_ch.last_digit),
        .i_char_unsup    (char_ch.unsupported),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_units         (units),
        .o_flagged_units (flagged_units)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_byte(logic [ByteW-1:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.byte_in <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly well-formed sequences with random payload, the rest raw noise
    task automatic send_random_sequence();
        int pick;
        int ones;
        logic [ByteW-1:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_byte(ByteW'($urandom_range(0, 255)));
        end else begin
            pick = $urandom_range(0, 11);
            if (pick < 3 || pick == 11) ones = 0;
            else if (pick < 6) ones = 2;
            else if (pick < 9) ones = 3;
            else if (pick == 9) ones = 4;
            else ones = $urandom_range(5, 8);
            if (ones == 0) begin
                lead = ByteW'($urandom_range(1, 127));
            end else begin
                lead = (8'hFF << (8 - ones)) | (ByteW'($urandom) & (8'hFF >> (ones + 1)));
            end
            send_byte(lead);
            for (int k = 1; k < ones; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(ByteW'($urandom_range(1, 255)));
                end else begin
                    send_byte(8'h80 | ByteW'($urandom_range(0, 63)));
                end
            end
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin : rx_side
        int hold_left;
        char_ch.ready = 1'b0;
        hold_ack      = 0;
        hold_left     = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                char_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                char_ch.ready <= 1'b0;
            end else if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                hold_left = HoldCycles - 1;
                char_ch.ready <= 1'b0;
            end else begin
                char_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready)
                || (char_ch.valid && char_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = '0;
        tx_idle_pct     = 18;
        rx_idle_pct     = 66;
        hold_req        = 0;
        sent_bytes      = 0;
        held            = 1'b0;
        paused          = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DirectedBytes[i]) begin
            send_byte(DirectedBytes[i]);
        end

        while (sent_bytes < ItemTarget) begin
            if (sent_bytes >= 210) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (sent_bytes >= 110) begin
                tx_idle_pct = 66;
                rx_idle_pct = 18;
            end
            // receiver blocks for a while so the queue fills and input stalls
            if (!held && sent_bytes >= 60) begin
                held = 1'b1;
                hold_req++;
            end
            if (!paused && sent_bytes >= 160) begin
                paused = 1'b1;
                wait_drained();
            end
            send_random_sequence();
        end

        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);

        $display("run: %0d bytes in, %0d code units checked, %0d of them flagged unsupported",
                 sent_bytes, units, flagged_units);
        $display("run: three idle mixes, one long output hold-off, one drain pause");
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
